### rtl/core/odo_pkg.sv
// ----------------------------------------------------------------------------
// Odometry package
// Shared constants, command and status types, and arithmetic helpers for the
// differential-drive odometry block.
// ----------------------------------------------------------------------------
package odo_pkg;

    // Default parameter values.
    localparam int ENC_BITS_DEF     = 16;
    localparam int CORDIC_STEPS_DEF = 20;

    // Fixed field widths.
    localparam int CNT_W   = 16;
    localparam int SCALE_W = 24;
    localparam int SEP_W   = 18;
    localparam int ACC_W   = 32;
    localparam int STEP_W  = 6;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MPT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_MPT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_SEP = 2'd2;

    // Configuration reset values.
    localparam logic [SCALE_W-1:0] RIGHT_MPT_RST = 24'd440006;
    localparam logic [SCALE_W-1:0] LEFT_MPT_RST  = 24'd440006;
    localparam logic [SEP_W-1:0]   WHEEL_SEP_RST = 18'd17039;

    // Angle arithmetic, Q30 radians.
    localparam int R_W      = 35;
    localparam int CS_W     = 32;
    localparam int MAG_W    = 46;
    localparam int RED_STEPS = 13;
    localparam int MCW      = 34;
    localparam logic signed [R_W-1:0] GAIN_Q30    = 35'sd652032874;
    localparam logic signed [R_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [R_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [R_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic [MAG_W-1:0]      TWO_PI_MAG  = 46'd6746518852;

    // Width of the heading-step quotient for a given encoder width.
    function automatic int quo_w(input int enc_bits);
        return enc_bits + SCALE_W + 5;
    endfunction

    // Datapath operations.
    typedef enum logic [4:0] {
        OP_IDLE, OP_LOAD, OP_MUL_R, OP_MUL_L, OP_ACC, OP_DIV, OP_HEAD,
        OP_RED_INIT, OP_RED, OP_FOLD1, OP_FOLD2, OP_CORD, OP_MUL_X,
        OP_MUL_Y, OP_RND_Y, OP_POS, OP_OUT
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic sep_zero;
    } stat_t;

    // Arctangent table, Q30 radians.
    function automatic logic signed [R_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [R_W-1:0] v;
        case (i)
            5'd0:  v = 35'sd843314856;
            5'd1:  v = 35'sd497837829;
            5'd2:  v = 35'sd263043836;
            5'd3:  v = 35'sd133525158;
            5'd4:  v = 35'sd67021686;
            5'd5:  v = 35'sd33543515;
            5'd6:  v = 35'sd16775850;
            5'd7:  v = 35'sd8388437;
            5'd8:  v = 35'sd4194282;
            5'd9:  v = 35'sd2097149;
            5'd10: v = 35'sd1048575;
            5'd11: v = 35'sd524287;
            5'd12: v = 35'sd262143;
            5'd13: v = 35'sd131071;
            5'd14: v = 35'sd65535;
            5'd15: v = 35'sd32767;
            5'd16: v = 35'sd16383;
            5'd17: v = 35'sd8191;
            5'd18: v = 35'sd4095;
            5'd19: v = 35'sd2047;
            5'd20: v = 35'sd1023;
            5'd21: v = 35'sd511;
            5'd22: v = 35'sd255;
            5'd23: v = 35'sd127;
            5'd24: v = 35'sd63;
            5'd25: v = 35'sd31;
            5'd26: v = 35'sd15;
            5'd27: v = 35'sd7;
            5'd28: v = 35'sd3;
            5'd29: v = 35'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Clip to the signed 32-bit range; the top bit flags a clip.
    function automatic logic [ACC_W:0] sat32(input logic signed [63:0] v);
        logic [ACC_W:0] r;
        if (v > 64'sd2147483647)
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -64'sd2147483648)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[ACC_W-1:0]};
        return r;
    endfunction

endpackage

### rtl/core/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// Differential-drive odometry
// Dead-reckoning pose from raw wheel encoder counts, fixed point.
//
//  Channel  Dir  Handshake               Payload
//  s_axis   in   s_axis_tvalid/tready    tdata: counts, tuser: action
//  m_axis   out  m_axis_tvalid/tready    tdata: travels, pose, tuser: saturated
//  cfg      in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// An update item passes through the one-bit-per-cycle divider for the heading
// step and the iterative CORDIC; with zero wheel separation the divider is
// skipped. A pose reset item goes from idle straight to the output hand-off.
// Reset clears the pose and the captured counts and loads the default
// configuration registers. A finished item waits in the output register; the
// next input item is taken while it waits, and the block holds the following
// result until the output register is free.
// ----------------------------------------------------------------------------
module differential_drive_odometry import odo_pkg::*; #(
    parameter int ENC_BITS     = ENC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // [15:0] right_count, [31:16] left_count
    input  logic [31:0]          s_axis_tdata,
    // [0] action
    input  logic                 s_axis_tuser,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [31:0] right_travel, [63:32] left_travel, [95:64] pos_x,
    // [127:96] pos_y, [159:128] heading
    output logic [159:0]         m_axis_tdata,
    // [0] saturated
    output logic                 m_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SCALE_W-1:0]   cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    logic [SCALE_W-1:0] rmpt_reg, lmpt_reg;
    logic [SEP_W-1:0]   sep_reg;
    logic               out_valid_reg;
    logic [159:0]       out_data_reg;
    logic               out_sat_reg;

    logic signed [ACC_W-1:0] right_travel, left_travel, pos_x, pos_y, heading;
    logic                    saturated;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rmpt_reg <= RIGHT_MPT_RST;
            lmpt_reg <= LEFT_MPT_RST;
            sep_reg  <= WHEEL_SEP_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RIGHT_MPT: rmpt_reg <= cfg_data;
                REG_LEFT_MPT:  lmpt_reg <= cfg_data;
                REG_WHEEL_SEP: sep_reg  <= cfg_data[SEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    odo_ctrl #(
        .ENC_BITS     (ENC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_free  (!out_valid_reg || m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    odo_dp #(
        .ENC_BITS (ENC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_action      (s_axis_tuser),
        .in_right_count (s_axis_tdata[15:0]),
        .in_left_count  (s_axis_tdata[31:16]),
        .right_mpt      (rmpt_reg),
        .left_mpt       (lmpt_reg),
        .wheel_sep      (sep_reg),
        .right_travel   (right_travel),
        .left_travel    (left_travel),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .heading        (heading),
        .saturated      (saturated)
    );

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_OUT)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_OUT)
        begin
            out_data_reg <= {heading, pos_y, pos_x, left_travel, right_travel};
            out_sat_reg  <= saturated;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_sat_reg;

endmodule

### rtl/core/odo_ctrl.sv
// ----------------------------------------------------------------------------
// Odometry controller
// Sequences one item through the datapath: wheel products, divider, angle
// reduction, CORDIC, projection and the hand-off to the output register.
// ----------------------------------------------------------------------------
module odo_ctrl import odo_pkg::*; #(
    parameter int ENC_BITS     = ENC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  in_action,
    output logic  in_ready,
    input  logic  out_free,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam int DIV_STEPS = quo_w(ENC_BITS);

    typedef enum logic [15:0] {
        S_IDLE     = 16'b0000_0000_0000_0001,
        S_MUL_R    = 16'b0000_0000_0000_0010,
        S_MUL_L    = 16'b0000_0000_0000_0100,
        S_ACC      = 16'b0000_0000_0000_1000,
        S_DIV      = 16'b0000_0000_0001_0000,
        S_HEAD     = 16'b0000_0000_0010_0000,
        S_RED_INIT = 16'b0000_0000_0100_0000,
        S_RED      = 16'b0000_0000_1000_0000,
        S_FOLD1    = 16'b0000_0001_0000_0000,
        S_FOLD2    = 16'b0000_0010_0000_0000,
        S_CORD     = 16'b0000_0100_0000_0000,
        S_MUL_X    = 16'b0000_1000_0000_0000,
        S_MUL_Y    = 16'b0001_0000_0000_0000,
        S_RND_Y    = 16'b0010_0000_0000_0000,
        S_POS      = 16'b0100_0000_0000_0000,
        S_DONE     = 16'b1000_0000_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    // Next-state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_IDLE;
        cmd.step   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = in_action ? S_MUL_R : S_DONE;
                end
            end
            S_MUL_R:
            begin
                cmd.op     = OP_MUL_R;
                state_next = S_MUL_L;
            end
            S_MUL_L:
            begin
                cmd.op     = OP_MUL_L;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op     = OP_ACC;
                cnt_next   = '0;
                state_next = stat.sep_zero ? S_HEAD : S_DIV;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = S_HEAD;
            end
            S_HEAD:
            begin
                cmd.op     = OP_HEAD;
                state_next = S_RED_INIT;
            end
            S_RED_INIT:
            begin
                cmd.op     = OP_RED_INIT;
                cnt_next   = '0;
                state_next = S_RED;
            end
            S_RED:
            begin
                cmd.op = OP_RED;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(RED_STEPS - 1))
                    state_next = S_FOLD1;
            end
            S_FOLD1:
            begin
                cmd.op     = OP_FOLD1;
                state_next = S_FOLD2;
            end
            S_FOLD2:
            begin
                cmd.op     = OP_FOLD2;
                cnt_next   = '0;
                state_next = S_CORD;
            end
            S_CORD:
            begin
                cmd.op = OP_CORD;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(CORDIC_STEPS - 1))
                    state_next = S_MUL_X;
            end
            S_MUL_X:
            begin
                cmd.op     = OP_MUL_X;
                state_next = S_MUL_Y;
            end
            S_MUL_Y:
            begin
                cmd.op     = OP_MUL_Y;
                state_next = S_RND_Y;
            end
            S_RND_Y:
            begin
                cmd.op     = OP_RND_Y;
                state_next = S_POS;
            end
            S_POS:
            begin
                cmd.op     = OP_POS;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### rtl/core/odo_dp.sv
// ----------------------------------------------------------------------------
// Odometry datapath
// Accumulators, shared wheel multiplier, restoring divider for the heading
// step, angle reduction, iterative CORDIC and the x/y projection.
// ----------------------------------------------------------------------------
module odo_dp import odo_pkg::*; #(
    parameter int ENC_BITS = ENC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output stat_t                     stat,
    input  logic                      in_action,
    input  logic [CNT_W-1:0]          in_right_count,
    input  logic [CNT_W-1:0]          in_left_count,
    input  logic [SCALE_W-1:0]        right_mpt,
    input  logic [SCALE_W-1:0]        left_mpt,
    input  logic [SEP_W-1:0]          wheel_sep,
    output logic signed [ACC_W-1:0]   right_travel,
    output logic signed [ACC_W-1:0]   left_travel,
    output logic signed [ACC_W-1:0]   pos_x,
    output logic signed [ACC_W-1:0]   pos_y,
    output logic signed [ACC_W-1:0]   heading,
    output logic                      saturated
);

    localparam int DW  = ENC_BITS + 1;
    localparam int PW  = DW + SCALE_W + 1;
    localparam int TW  = PW - 14;
    localparam int MW  = TW + 1;
    localparam int UW  = quo_w(ENC_BITS);
    localparam int HSW = UW + 2;
    localparam int AW  = ((TW > ACC_W) ? TW : ACC_W) + 1;
    localparam int CW  = ((MW > MCW) ? MW : MCW) + 1;
    localparam int PW2 = MCW + CS_W;
    localparam int XW  = PW2 - 29;
    localparam int XSW = XW + 1;

    localparam logic signed [DW-1:0] HALF_CNT = {2'b01, {(ENC_BITS-1){1'b0}}};
    localparam logic signed [DW-1:0] FULL_CNT = {1'b1, {ENC_BITS{1'b0}}};
    localparam logic signed [CW-1:0] M_MAX = CW'(64'sd4294967295);
    localparam logic signed [CW-1:0] M_MIN = CW'(-64'sd4294967296);

    // Count change, unwrapped around the counter modulus.
    function automatic logic signed [DW-1:0] unwrap(input logic [ENC_BITS-1:0] cur,
                                                    input logic [ENC_BITS-1:0] old);
        logic signed [DW-1:0] d;
        d = $signed({1'b0, cur}) - $signed({1'b0, old});
        if (d > HALF_CNT)
            d = d - FULL_CNT;
        else if (d < -HALF_CNT)
            d = d + FULL_CNT;
        return d;
    endfunction

    // Round to nearest, ties away from zero, dropping 16 bits.
    function automatic logic signed [TW-1:0] round16(input logic signed [PW-1:0] v);
        logic [PW-1:0]  mag;
        logic [PW:0]    sum;
        logic [TW-1:0]  r;
        mag = v[PW-1] ? -v : v;
        sum = {1'b0, mag} + (PW+1)'(32768);
        r   = {1'b0, sum[PW:16]};
        return v[PW-1] ? -$signed(r) : $signed(r);
    endfunction

    // Round to nearest, ties away from zero, dropping 31 bits.
    function automatic logic signed [XW-1:0] round31(input logic signed [PW2-1:0] v);
        logic [PW2-1:0] mag;
        logic [PW2:0]   sum;
        logic [XW-1:0]  r;
        mag = v[PW2-1] ? -v : v;
        sum = {1'b0, mag} + (PW2+1)'(64'd1073741824);
        r   = {1'b0, sum[PW2:31]};
        return v[PW2-1] ? -$signed(r) : $signed(r);
    endfunction

    // State and accumulator registers (reset to zero).
    logic [ENC_BITS-1:0]      last_r_reg, last_r_next, last_l_reg, last_l_next;
    logic signed [ACC_W-1:0]  rtrav_reg, rtrav_next, ltrav_reg, ltrav_next;
    logic signed [ACC_W-1:0]  x_reg, x_next, y_reg, y_next, head_reg, head_next;
    logic                     sat_reg, sat_next;

    // Working registers.
    logic [ENC_BITS-1:0]      rc_reg, rc_next, lc_reg, lc_next;
    logic signed [PW-1:0]     prod_reg, prod_next;
    logic signed [TW-1:0]     dr_reg, dr_next;
    logic signed [MCW-1:0]    m_reg, m_next;
    logic                     dneg_reg, dneg_next;
    logic [UW-1:0]            quo_reg, quo_next;
    logic [SEP_W-1:0]         rem_reg, rem_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic                     hneg_reg, hneg_next;
    logic signed [R_W-1:0]    r_reg, r_next;
    logic signed [CS_W-1:0]   cx_reg, cx_next, cy_reg, cy_next;
    logic                     fneg_reg, fneg_next;
    logic signed [PW2-1:0]    prod2_reg, prod2_next;
    logic signed [XW-1:0]     xs_reg, xs_next, ys_reg, ys_next;

    // Combinational helpers.
    logic signed [DW-1:0]     mul_a;
    logic signed [SCALE_W:0]  mul_b;
    logic signed [TW-1:0]     dl;
    logic signed [MW-1:0]     diff, msum;
    logic [MW-1:0]            diff_mag;
    logic signed [CW-1:0]     m_w;
    logic signed [AW-1:0]     rt_sum, lt_sum;
    logic signed [HSW-1:0]    h_sum;
    logic signed [UW:0]       dth;
    logic [SEP_W:0]           rem_sh;
    logic signed [MAG_W-1:0]  hv;
    logic [MAG_W-1:0]         red_sub;
    logic [3:0]               red_k;
    logic signed [R_W-1:0]    r0;
    logic [4:0]               ci;
    logic signed [CS_W-1:0]   dx, dy, cm;
    logic signed [XSW-1:0]    x_sum, y_sum;
    logic [ACC_W:0]           s_a, s_b;

    assign stat.sep_zero = (wheel_sep == '0);

    // Operation decode.
    always_comb
    begin
        last_r_next = last_r_reg;
        last_l_next = last_l_reg;
        rtrav_next  = rtrav_reg;
        ltrav_next  = ltrav_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        head_next   = head_reg;
        sat_next    = sat_reg;
        rc_next     = rc_reg;
        lc_next     = lc_reg;
        prod_next   = prod_reg;
        dr_next     = dr_reg;
        m_next      = m_reg;
        dneg_next   = dneg_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        mag_next    = mag_reg;
        hneg_next   = hneg_reg;
        r_next      = r_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        fneg_next   = fneg_reg;
        prod2_next  = prod2_reg;
        xs_next     = xs_reg;
        ys_next     = ys_reg;

        mul_a    = (cmd.op == OP_MUL_R) ? unwrap(rc_reg, last_r_reg)
                                        : unwrap(lc_reg, last_l_reg);
        mul_b    = $signed({1'b0, (cmd.op == OP_MUL_R) ? right_mpt : left_mpt});
        dl       = round16(prod_reg);
        diff     = MW'(dr_reg) - MW'(dl);
        msum     = MW'(dr_reg) + MW'(dl);
        diff_mag = diff[MW-1] ? -diff : diff;
        m_w      = CW'(msum);
        rt_sum   = AW'(rtrav_reg) + AW'(dr_reg);
        lt_sum   = AW'(ltrav_reg) + AW'(dl);
        dth      = dneg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        h_sum    = HSW'(head_reg) + HSW'(dth);
        rem_sh   = {rem_reg, quo_reg[UW-1]};
        hv       = {head_reg, 14'b0};
        red_k    = 4'(RED_STEPS - 1) - cmd.step[3:0];
        red_sub  = TWO_PI_MAG << red_k;
        r0       = (hneg_reg && (mag_reg != '0)) ? TWO_PI_Q30 - R_W'(mag_reg)
                                                 : R_W'(mag_reg);
        ci       = cmd.step[4:0];
        dx       = cy_reg >>> ci;
        dy       = cx_reg >>> ci;
        cm       = fneg_reg ? -cx_reg : cx_reg;
        x_sum    = XSW'(x_reg) + XSW'(xs_reg);
        y_sum    = XSW'(y_reg) + XSW'(ys_reg);
        s_a      = sat32(64'(rt_sum));
        s_b      = sat32(64'(lt_sum));

        unique case (cmd.op)
            OP_LOAD:
            begin
                rc_next  = ENC_BITS'(in_right_count);
                lc_next  = ENC_BITS'(in_left_count);
                sat_next = 1'b0;
                if (!in_action)
                begin
                    last_r_next = ENC_BITS'(in_right_count);
                    last_l_next = ENC_BITS'(in_left_count);
                    rtrav_next  = '0;
                    ltrav_next  = '0;
                    x_next      = '0;
                    y_next      = '0;
                    head_next   = '0;
                end
            end
            OP_MUL_R:
            begin
                prod_next = mul_a * mul_b;
            end
            OP_MUL_L:
            begin
                dr_next   = round16(prod_reg);
                prod_next = mul_a * mul_b;
            end
            OP_ACC:
            begin
                last_r_next = rc_reg;
                last_l_next = lc_reg;
                s_a = sat32(64'(rt_sum));
                s_b = sat32(64'(lt_sum));
                rtrav_next = $signed(s_a[ACC_W-1:0]);
                ltrav_next = $signed(s_b[ACC_W-1:0]);
                dneg_next  = diff[MW-1];
                quo_next   = {diff_mag, 16'b0} + UW'(wheel_sep[SEP_W-1:1]);
                rem_next   = '0;
                // Mean travel is clipped to the signed 33-bit range.
                if (m_w > M_MAX)
                begin
                    m_next   = MCW'(M_MAX);
                    sat_next = 1'b1;
                end
                else if (m_w < M_MIN)
                begin
                    m_next   = MCW'(M_MIN);
                    sat_next = 1'b1;
                end
                else
                begin
                    m_next   = MCW'(m_w);
                    sat_next = sat_reg | s_a[ACC_W] | s_b[ACC_W];
                end
                if (s_a[ACC_W] || s_b[ACC_W])
                    sat_next = 1'b1;
            end
            OP_DIV:
            begin
                if (rem_sh >= {1'b0, wheel_sep})
                begin
                    rem_next = SEP_W'(rem_sh - {1'b0, wheel_sep});
                    quo_next = {quo_reg[UW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[SEP_W-1:0];
                    quo_next = {quo_reg[UW-2:0], 1'b0};
                end
            end
            OP_HEAD:
            begin
                if (!stat.sep_zero)
                begin
                    s_a       = sat32(64'(h_sum));
                    head_next = $signed(s_a[ACC_W-1:0]);
                    sat_next  = sat_reg | s_a[ACC_W];
                end
            end
            OP_RED_INIT:
            begin
                hneg_next = head_reg[ACC_W-1];
                mag_next  = head_reg[ACC_W-1] ? MAG_W'(-hv) : MAG_W'(hv);
            end
            OP_RED:
            begin
                if (mag_reg >= red_sub)
                    mag_next = mag_reg - red_sub;
            end
            OP_FOLD1:
            begin
                r_next = (r0 > PI_Q30) ? r0 - TWO_PI_Q30 : r0;
            end
            OP_FOLD2:
            begin
                cx_next = CS_W'(GAIN_Q30);
                cy_next = '0;
                if (r_reg > HALF_PI_Q30)
                begin
                    r_next    = r_reg - PI_Q30;
                    fneg_next = 1'b1;
                end
                else if (r_reg < -HALF_PI_Q30)
                begin
                    r_next    = r_reg + PI_Q30;
                    fneg_next = 1'b1;
                end
                else
                begin
                    fneg_next = 1'b0;
                end
            end
            OP_CORD:
            begin
                if (r_reg >= 0)
                begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    r_next  = r_reg - atan_q30(ci);
                end
                else
                begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    r_next  = r_reg + atan_q30(ci);
                end
            end
            OP_MUL_X:
            begin
                prod2_next = m_reg * cm;
            end
            OP_MUL_Y:
            begin
                xs_next    = round31(prod2_reg);
                prod2_next = m_reg * (fneg_reg ? -cy_reg : cy_reg);
            end
            OP_RND_Y:
            begin
                ys_next = round31(prod2_reg);
            end
            OP_POS:
            begin
                s_a      = sat32(64'(x_sum));
                s_b      = sat32(64'(y_sum));
                x_next   = $signed(s_a[ACC_W-1:0]);
                y_next   = $signed(s_b[ACC_W-1:0]);
                sat_next = sat_reg | s_a[ACC_W] | s_b[ACC_W];
            end
            default:
            begin
            end
        endcase
    end

    // Pose state, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_r_reg <= '0;
            last_l_reg <= '0;
            rtrav_reg  <= '0;
            ltrav_reg  <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            head_reg   <= '0;
            sat_reg    <= 1'b0;
        end
        else
        begin
            last_r_reg <= last_r_next;
            last_l_reg <= last_l_next;
            rtrav_reg  <= rtrav_next;
            ltrav_reg  <= ltrav_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            head_reg   <= head_next;
            sat_reg    <= sat_next;
        end
    end

    // Working registers, rewritten before use by every item.
    always_ff @(posedge clk)
    begin
        rc_reg    <= rc_next;
        lc_reg    <= lc_next;
        prod_reg  <= prod_next;
        dr_reg    <= dr_next;
        m_reg     <= m_next;
        dneg_reg  <= dneg_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        mag_reg   <= mag_next;
        hneg_reg  <= hneg_next;
        r_reg     <= r_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        fneg_reg  <= fneg_next;
        prod2_reg <= prod2_next;
        xs_reg    <= xs_next;
        ys_reg    <= ys_next;
    end

    assign right_travel = rtrav_reg;
    assign left_travel  = ltrav_reg;
    assign pos_x        = x_reg;
    assign pos_y        = y_reg;
    assign heading      = head_reg;
    assign saturated    = sat_reg;

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Odometry block testbench
// Drives encoder count items through the stream input, with configuration
// changes between phases, and checks every pose item on the stream output
// against a fixed-point dead-reckoning predictor kept in this file.
// ----------------------------------------------------------------------------
module testbench;
    import odo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 5000;
    localparam int DRAIN_WAIT  = 120;
    localparam int ROT_STEPS   = 20;
    localparam int ITEMS_PHASE = 305;

    localparam longint GAIN_FX    = 64'sd652032874;
    localparam longint PI_FX      = 64'sd3373259426;
    localparam longint HALF_PI_FX = 64'sd1686629713;
    localparam longint TWO_PI_FX  = 64'sd6746518852;
    localparam longint ANGLE_TBL [ROT_STEPS] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047
    };

    // Action codes of the input item.
    localparam logic ACT_ZERO_POSE = 1'b0;
    localparam logic ACT_UPDATE    = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic [31:0] right_travel;
        logic [31:0] left_travel;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] heading;
        logic        saturated;
    } pose_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic [31:0]          s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [159:0]         m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SCALE_W-1:0]   cfg_data = '0;

    // Predictor state and configuration copy.
    logic [SCALE_W-1:0] scale_right, scale_left;
    logic [SEP_W-1:0]   separation;
    logic [15:0]        prev_right, prev_left;
    longint             acc_right, acc_left, acc_x, acc_y, acc_heading;

    pose_t  pending_poses [$];
    int     mismatches = 0;
    int     poses_checked = 0;
    int     sat_seen = 0;
    int     idle_cycles = 0;
    bit     no_idle = 1'b0;
    logic [15:0] sent_right = '0, sent_left = '0;

    differential_drive_odometry dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // Mostly short gaps, a few long ones, none while idling is switched off.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic longint clip32(input longint v, inout bit clipped);
        if (v > 64'sd2147483647)
        begin
            clipped = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            clipped = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Round to nearest, ties away from zero.
    function automatic longint round_div_pow2(input longint v, input int sh);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
        return (v < 0) ? -mag : mag;
    endfunction

    // Unwrap a 16-bit counter change; both half values are kept as they are.
    function automatic longint tick_delta(input logic [15:0] cur, input logic [15:0] old);
        longint d;
        d = longint'(cur) - longint'(old);
        if (d > 32768)
            d -= 65536;
        else if (d < -32768)
            d += 65536;
        return d;
    endfunction

    // Rotation by iterations on the heading, reduced and folded to +-pi/2.
    function automatic void heading_to_dir(input longint hd, output longint c,
                                           output longint s);
        longint r, x, y, dx, dy;
        bit     flip;
        r = (hd * 16384) % TWO_PI_FX;
        x = GAIN_FX;
        y = 0;
        flip = 1'b0;
        if (r < 0)
            r += TWO_PI_FX;
        if (r > PI_FX)
            r -= TWO_PI_FX;
        if (r > HALF_PI_FX)
        begin
            r -= PI_FX;
            flip = 1'b1;
        end
        else if (r < -HALF_PI_FX)
        begin
            r += PI_FX;
            flip = 1'b1;
        end
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (r >= 0)
            begin
                x -= dx;
                y += dy;
                r -= ANGLE_TBL[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                r += ANGLE_TBL[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // Advance the pose for one accepted item and return the expected output.
    function automatic pose_t advance_pose(input logic act, input logic [15:0] rc,
                                           input logic [15:0] lc);
        pose_t  p;
        bit     clipped;
        longint dr, dl, diff, mean, quo, c, s;
        clipped = 1'b0;
        if (act == ACT_ZERO_POSE)
        begin
            acc_right = 0;
            acc_left = 0;
            acc_x = 0;
            acc_y = 0;
            acc_heading = 0;
        end
        else
        begin
            dr = round_div_pow2(tick_delta(rc, prev_right) * longint'(scale_right), 16);
            dl = round_div_pow2(tick_delta(lc, prev_left) * longint'(scale_left), 16);
            diff = dr - dl;
            mean = dr + dl;
            acc_right = clip32(acc_right + dr, clipped);
            acc_left = clip32(acc_left + dl, clipped);
            if (separation != 0)
            begin
                quo = (((diff < 0) ? -diff : diff) * 65536 + longint'(separation) / 2)
                      / longint'(separation);
                acc_heading = clip32(acc_heading + ((diff < 0) ? -quo : quo), clipped);
            end
            if (mean > 64'sd4294967295)
            begin
                mean = 64'sd4294967295;
                clipped = 1'b1;
            end
            else if (mean < -64'sd4294967296)
            begin
                mean = -64'sd4294967296;
                clipped = 1'b1;
            end
            heading_to_dir(acc_heading, c, s);
            acc_x = clip32(acc_x + round_div_pow2(mean * c, 31), clipped);
            acc_y = clip32(acc_y + round_div_pow2(mean * s, 31), clipped);
        end
        prev_right = rc;
        prev_left = lc;
        p.right_travel = acc_right[31:0];
        p.left_travel = acc_left[31:0];
        p.pos_x = acc_x[31:0];
        p.pos_y = acc_y[31:0];
        p.heading = acc_heading[31:0];
        p.saturated = clipped;
        return p;
    endfunction

    // Send one count item and predict its pose when it is accepted.
    task automatic send_counts(input logic act, input logic [15:0] rc, input logic [15:0] lc);
        int gap;
        gap = gap_len();
        repeat (gap) @(negedge clk);
        s_axis_tdata = {lc, rc};
        s_axis_tuser = act;
        s_axis_tvalid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (s_axis_tready)
                break;
        end
        pending_poses.push_back(advance_pose(act, rc, lc));
        sent_right = rc;
        sent_left = lc;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        s_axis_tdata = $urandom;
    endtask

    // Write one register once every pending pose has come out and the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] val);
        wait (pending_poses.size() == 0);
        repeat (DRAIN_WAIT) @(negedge clk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        case (idx)
            REG_RIGHT_MPT: scale_right = val;
            REG_LEFT_MPT:  scale_left = val;
            REG_WHEEL_SEP: separation = val[SEP_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_geometry(input logic [SCALE_W-1:0] r, input logic [SCALE_W-1:0] l,
                                input logic [SCALE_W-1:0] sep);
        write_reg(REG_RIGHT_MPT, r);
        write_reg(REG_LEFT_MPT, l);
        write_reg(REG_WHEEL_SEP, sep);
    endtask

    // Per-wheel count change: mostly slow travel, some fast, hard pushes when asked.
    function automatic logic [15:0] next_count(input logic [15:0] cur, input bit hard,
                                               input bit reverse);
        int r;
        r = $urandom_range(0, 99);
        if (hard)
            return reverse ? cur - 16'($urandom_range(20000, 32768))
                           : cur + 16'($urandom_range(20000, 32768));
        if (r < 75)
            return cur + 16'($urandom_range(0, 300)) - 16'($urandom_range(0, 60));
        if (r < 92)
            return cur + 16'($urandom_range(0, 10000)) - 16'($urandom_range(0, 10000));
        return 16'($urandom);
    endfunction

    task automatic run_random(input int count, input bit hard);
        int  r;
        bit  reverse;
        reverse = $urandom_range(0, 1);
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                send_counts(ACT_ZERO_POSE, 16'($urandom), 16'($urandom));
            else
                send_counts(ACT_UPDATE, next_count(sent_right, hard, reverse),
                            next_count(sent_left, hard && r < 70, !reverse));
        end
    endtask

    // Extremes of the counts, half-range steps, wrap-around and pose zeroing.
    task automatic test_directed();
        send_counts(ACT_ZERO_POSE, 16'h1234, 16'hFEDC);
        send_counts(ACT_UPDATE, 16'h1234, 16'hFEDC);
        send_counts(ACT_UPDATE, 16'h9234, 16'h7EDC);
        send_counts(ACT_UPDATE, 16'h1234, 16'hFEDC);
        send_counts(ACT_ZERO_POSE, 16'hFFFF, 16'h0000);
        send_counts(ACT_UPDATE, 16'h0001, 16'hFFFE);
        send_counts(ACT_UPDATE, 16'h8001, 16'h7FFE);
        send_counts(ACT_UPDATE, 16'h0000, 16'hFFFF);
        send_counts(ACT_UPDATE, 16'hFFFF, 16'h0000);
        send_counts(ACT_UPDATE, 16'h0FFF, 16'h0FFF);
        send_counts(ACT_UPDATE, 16'h1FFF, 16'h1FFF);
        send_counts(ACT_ZERO_POSE, 16'h0000, 16'h0000);
        send_counts(ACT_UPDATE, 16'h7FFF, 16'h8000);
        send_counts(ACT_UPDATE, 16'h0000, 16'h0000);
        send_counts(ACT_UPDATE, 16'h8000, 16'h8000);
    endtask

    task automatic test_default_geometry();
        run_random(ITEMS_PHASE, 1'b0);
    endtask

    // Largest scales and the narrowest wheel base drive every accumulator to clip.
    task automatic test_saturation();
        set_geometry(24'hFFFFFF, 24'hFFFFFF, 24'hFC0001);
        run_random(ITEMS_PHASE, 1'b1);
    endtask

    // Smallest scales, widest wheel base, and back-to-back items with no idling.
    task automatic test_fine_scale_no_idle();
        set_geometry(24'd1, 24'd1, 24'h03FFFF);
        no_idle = 1'b1;
        run_random(ITEMS_PHASE, 1'b0);
        no_idle = 1'b0;
    endtask

    // A zero scale on each wheel in turn and zero wheel separation: the heading must stay put.
    task automatic test_zero_scale_and_separation();
        set_geometry(24'd0, 24'd440006, 24'd0);
        run_random(ITEMS_PHASE / 2, 1'b0);
        set_geometry(24'd440006, 24'd0, 24'd0);
        run_random(ITEMS_PHASE / 2, 1'b0);
    endtask

    // Random geometry, including a write to the unused register index.
    task automatic test_random_geometry();
        for (int k = 0; k < 2; k++)
        begin
            set_geometry(24'($urandom), 24'($urandom), 24'($urandom));
            write_reg(REG_SPARE, 24'($urandom));
            run_random(ITEMS_PHASE, k == 1);
        end
    endtask

    // Output stall: random lengths, mostly short.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= (gap_len() == 0);
    end

    // Compare each pose item with the oldest prediction.
    always @(posedge clk)
    begin
        pose_t exp_pose;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_poses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected pose item: %h", m_axis_tdata);
            end
            else
            begin
                exp_pose = pending_poses.pop_front();
                poses_checked++;
                if (exp_pose.saturated)
                    sat_seen++;
                if (m_axis_tdata[31:0] !== exp_pose.right_travel
                    || m_axis_tdata[63:32] !== exp_pose.left_travel
                    || m_axis_tdata[95:64] !== exp_pose.pos_x
                    || m_axis_tdata[127:96] !== exp_pose.pos_y
                    || m_axis_tdata[159:128] !== exp_pose.heading
                    || m_axis_tuser !== exp_pose.saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Pose mismatch: expected r=%h l=%h x=%h y=%h h=%h s=%b, got r=%h l=%h x=%h y=%h h=%h s=%b",
                                 exp_pose.right_travel, exp_pose.left_travel,
                                 exp_pose.pos_x, exp_pose.pos_y, exp_pose.heading,
                                 exp_pose.saturated, m_axis_tdata[31:0],
                                 m_axis_tdata[63:32], m_axis_tdata[95:64],
                                 m_axis_tdata[127:96], m_axis_tdata[159:128],
                                 m_axis_tuser);
                end
            end
        end
    end

    // Watchdog on cycles in which no channel moves an item.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("Timeout with %0d poses outstanding", pending_poses.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        scale_right = RIGHT_MPT_RST;
        scale_left = LEFT_MPT_RST;
        separation = WHEEL_SEP_RST;
        prev_right = '0;
        prev_left = '0;
        acc_right = 0;
        acc_left = 0;
        acc_x = 0;
        acc_y = 0;
        acc_heading = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_default_geometry();
        test_saturation();
        test_fine_scale_no_idle();
        test_zero_scale_and_separation();
        test_random_geometry();

        wait (pending_poses.size() == 0);
        repeat (DRAIN_WAIT) @(negedge clk);
        $display("Checked %0d pose items (%0d with clipping) over seven wheel geometries,",
                 poses_checked, sat_seen);
        $display("including zero scale, zero separation and the register extremes.");
        if (mismatches == 0 && pending_poses.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### differential_drive_odometry.f
rtl/core/odo_pkg.sv
rtl/core/odo_ctrl.sv
rtl/core/odo_dp.sv
rtl/core/differential_drive_odometry.sv
sim/testbench.sv
